// File: rtl/core/i2csrf_pkg.sv
// ============================================================================
// i2csrf_pkg
// Types and constants shared by the slave bus register file core.
// ============================================================================
package i2csrf_pkg;

  // Bus and local event codes carried in the input tuser field
  typedef enum logic [2:0] {
    MODE_TX_MATCH = 3'd0,
    MODE_RX_MATCH = 3'd1,
    MODE_BYTE_RX  = 3'd2,
    MODE_TX_REQ   = 3'd3,
    MODE_STOP     = 3'd4,
    MODE_TX_DONE  = 3'd5,
    MODE_LOC_WR   = 3'd6,
    MODE_LOC_RD   = 3'd7
  } mode_e;

  // Frame layout: [op, address, length or data...]
  localparam int unsigned HDR_OP       = 0;
  localparam int unsigned HDR_ADDR     = 1;
  localparam int unsigned HDR_LEN      = 2;
  localparam int unsigned HDR_MIN_LEN  = 3;
  localparam int unsigned WF_DATA_OFS  = 2;
  localparam logic [7:0]  FRAME_READ   = 8'd0;
  localparam logic [7:0]  FRAME_WRITE  = 8'd1;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned RES_W      = 18;
  localparam int unsigned OUT_DATA_W = 24;

  // Control of the shared index/address unit
  typedef struct packed {
    logic load;
    logic advance;
  } step_ctrl_t;

  // Status of the shared index/address unit
  typedef struct packed {
    logic more;
    logic in_reg;
    logic in_motion;
  } step_stat_t;

endpackage

// File: rtl/core/i2csrf_regfile.sv
// ============================================================================
// i2csrf_regfile
// Byte register file: one write port, one registered read port, and a valid
// bit per entry so that entries never written read as zero after reset.
// ============================================================================
module i2csrf_regfile #(
  parameter  int unsigned REG_COUNT = 32,
  localparam int unsigned RA_W      = $clog2(REG_COUNT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [RA_W-1:0] wr_addr_i,
  input  logic [7:0]      wr_data_i,
  input  logic            rd_en_i,
  input  logic [RA_W-1:0] rd_addr_i,
  input  logic            rd_ok_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0]           mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] valid_q;
  logic [7:0]           raw_q;
  logic                 hit_q;

  // Store write data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Mark written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      raw_q <= mem_q[rd_addr_i];
    end
  end

  // Register hit: in range and written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (rd_en_i) begin
      hit_q <= rd_ok_i && valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = hit_q ? raw_q : 8'h00;

endmodule

// File: rtl/core/i2csrf_fbuf.sv
// ============================================================================
// i2csrf_fbuf
// Frame buffer: byte memory with one write port and one registered read port.
// ============================================================================
module i2csrf_fbuf #(
  parameter  int unsigned BUFFER_DEPTH = 32,
  localparam int unsigned BA_W         = $clog2(BUFFER_DEPTH)
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [BA_W-1:0] wr_addr_i,
  input  logic [7:0]      wr_data_i,
  input  logic            rd_en_i,
  input  logic [BA_W-1:0] rd_addr_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0] mem_q [BUFFER_DEPTH];
  logic [7:0] rd_q;

  // Store write data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: rtl/core/i2csrf_step.sv
// ============================================================================
// i2csrf_step
// Shared index/address unit: an index counter with a loop limit, one adder
// that forms base + index, and the range compares used by every block loop.
// ============================================================================
module i2csrf_step
  import i2csrf_pkg::*;
#(
  parameter int unsigned IDX_W        = 6,
  parameter int unsigned SUM_W        = 9,
  parameter int unsigned REG_COUNT    = 32,
  parameter int unsigned MOTION_COUNT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  step_ctrl_t       ctrl_i,
  input  logic [IDX_W-1:0] start_i,
  input  logic [IDX_W-1:0] limit_i,
  input  logic [SUM_W-1:0] base_i,
  output logic [IDX_W-1:0] idx_o,
  output logic [SUM_W-1:0] sum_o,
  output step_stat_t       stat_o
);

  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] limit_q;
  logic [SUM_W-1:0] base_q;
  logic [SUM_W-1:0] sum;

  // Load a new loop or advance the index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      limit_q <= '0;
      base_q  <= '0;
    end else if (ctrl_i.load) begin
      idx_q   <= start_i;
      limit_q <= limit_i;
      base_q  <= base_i;
    end else if (ctrl_i.advance) begin
      idx_q   <= idx_q + 1'b1;
    end
  end

  // Form the address and compare it against the register regions
  assign sum              = base_q + SUM_W'(idx_q);
  assign stat_o.more      = idx_q < limit_q;
  assign stat_o.in_reg    = sum < SUM_W'(REG_COUNT);
  assign stat_o.in_motion = sum < SUM_W'(MOTION_COUNT);

  assign idx_o = idx_q;
  assign sum_o = sum;

endmodule

// File: rtl/core/i2c_slave_register_file_core.sv
// ============================================================================
// i2c_slave_register_file_core
// Slave bus event handler in front of a byte register file.
// ============================================================================
// Each input transaction is one event (tuser) with a data byte and a local
// register index (tdata), and yields exactly one result transaction. The
// block takes one event at a time; s_axis_tready is high only while idle, but
// a finished result may still wait in the output register on m_axis_tready.
// A tx match or stop is turned away before its header is fetched when fewer
// than three bytes are held, or, for a stop, when the write frame is too long.
// Block copies run through one shared index/address unit and the register
// file and frame buffer, each with one write and one read port; a copied byte
// takes a read state and a write state, and a cleared register one state.
module i2c_slave_register_file_core
  import i2csrf_pkg::*;
#(
  parameter int unsigned REG_COUNT    = 32,
  parameter int unsigned MOTION_COUNT = 8,
  parameter int unsigned BUFFER_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] data_byte, [12:8] reg_addr, [15:13] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [2:0] mode
  input  logic [2:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] tx_byte, [8] tx_valid, [9] config_updated, [17:10] read_data,
  // [23:18] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned RA_W  = $clog2(REG_COUNT);
  localparam int unsigned BA_W  = $clog2(BUFFER_DEPTH);
  localparam int unsigned LEN_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned SUM_W = ((LEN_W > 8) ? LEN_W : 8) + 1;
  localparam int unsigned CHK_W = SUM_W + 1;

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_HDR0    = 14'b00000000000010,
    ST_HDR1    = 14'b00000000000100,
    ST_HDR2    = 14'b00000000001000,
    ST_HDR3    = 14'b00000000010000,
    ST_SNAP_RD = 14'b00000000100000,
    ST_SNAP_WR = 14'b00000001000000,
    ST_CLR     = 14'b00000010000000,
    ST_WF_RD   = 14'b00000100000000,
    ST_WF_WR   = 14'b00001000000000,
    ST_TX_RD   = 14'b00010000000000,
    ST_TX_CAP  = 14'b00100000000000,
    ST_LOC_CAP = 14'b01000000000000,
    ST_EMIT    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Architectural state
  logic [LEN_W-1:0] fl_q, fl_d;
  logic [LEN_W-1:0] send_q, send_d;
  logic [7:0]       read_base_q, read_base_d;

  // Per-event working registers
  mode_e      mode_q, mode_d;
  logic [7:0] b0_q, b0_d;
  logic [7:0] b1_q, b1_d;
  logic [7:0] res_tx_q, res_tx_d;
  logic       res_txv_q, res_txv_d;
  logic       res_upd_q, res_upd_d;
  logic [7:0] res_rd_q, res_rd_d;

  // Output register
  logic             m_valid_q, m_valid_d;
  logic [RES_W-1:0] m_data_q, m_data_d;

  // Input fields
  mode_e      in_mode;
  logic [7:0] in_data;
  logic [4:0] in_addr;
  logic       in_addr_ok;

  // Memory ports
  logic            buf_we, buf_re;
  logic [BA_W-1:0] buf_wa, buf_ra;
  logic [7:0]      buf_wd, buf_rd;
  logic            reg_we, reg_re, reg_ok;
  logic [RA_W-1:0] reg_wa, reg_ra;
  logic [7:0]      reg_wd, reg_rd;

  // Shared unit ports
  step_ctrl_t       step_ctrl;
  step_stat_t       step_stat;
  logic [LEN_W-1:0] step_start, step_limit, step_idx;
  logic [SUM_W-1:0] step_base, step_sum;

  // Frame checks
  logic             wf_len_ok;
  logic [SUM_W-1:0] snap_len_w;
  logic [LEN_W-1:0] snap_len;

  assign in_mode    = mode_e'(s_axis_tuser);
  assign in_data    = s_axis_tdata[7:0];
  assign in_addr    = s_axis_tdata[12:8];
  assign in_addr_ok = SUM_W'(in_addr) < SUM_W'(REG_COUNT);

  assign wf_len_ok  = (CHK_W'(fl_q) + CHK_W'(MOTION_COUNT))
                      < CHK_W'(REG_COUNT + HDR_MIN_LEN);
  assign snap_len_w = (SUM_W'(buf_rd) > SUM_W'(BUFFER_DEPTH)) ?
                      SUM_W'(BUFFER_DEPTH) : SUM_W'(buf_rd);
  assign snap_len   = LEN_W'(snap_len_w);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, m_data_q};

  // Sequence the event handling
  always_comb begin
    state_d     = state_q;
    fl_d        = fl_q;
    send_d      = send_q;
    read_base_d = read_base_q;
    mode_d      = mode_q;
    b0_d        = b0_q;
    b1_d        = b1_q;
    res_tx_d    = res_tx_q;
    res_txv_d   = res_txv_q;
    res_upd_d   = res_upd_q;
    res_rd_d    = res_rd_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    buf_we      = 1'b0;
    buf_wa      = '0;
    buf_wd      = '0;
    buf_re      = 1'b0;
    buf_ra      = '0;
    reg_we      = 1'b0;
    reg_wa      = '0;
    reg_wd      = '0;
    reg_re      = 1'b0;
    reg_ra      = '0;
    reg_ok      = 1'b0;
    step_ctrl   = '0;
    step_start  = '0;
    step_limit  = '0;
    step_base   = '0;

    // Drop the output once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d    = in_mode;
          res_tx_d  = 8'h00;
          res_txv_d = 1'b0;
          res_upd_d = 1'b0;
          res_rd_d  = 8'h00;
          state_d   = ST_EMIT;
          unique case (in_mode)
            MODE_TX_MATCH: begin
              if (fl_q >= LEN_W'(HDR_MIN_LEN)) begin
                state_d = ST_HDR0;
              end
            end
            MODE_RX_MATCH: begin
              fl_d = '0;
            end
            MODE_BYTE_RX: begin
              if (fl_q < LEN_W'(BUFFER_DEPTH)) begin
                buf_we = 1'b1;
                buf_wa = fl_q[BA_W-1:0];
                buf_wd = in_data;
                fl_d   = fl_q + 1'b1;
              end
            end
            MODE_TX_REQ: begin
              if (fl_q > send_q) begin
                state_d = ST_TX_RD;
              end else begin
                // Clear the motion registers covered by the last snapshot
                step_ctrl.load = 1'b1;
                step_start     = '0;
                step_limit     = fl_q;
                step_base      = SUM_W'(read_base_q);
                state_d        = ST_CLR;
              end
            end
            MODE_STOP: begin
              if (fl_q >= LEN_W'(HDR_MIN_LEN) && wf_len_ok) begin
                state_d = ST_HDR0;
              end
            end
            MODE_TX_DONE: begin
              res_txv_d = 1'b1;
            end
            MODE_LOC_WR: begin
              reg_we = in_addr_ok;
              reg_wa = RA_W'(in_addr);
              reg_wd = in_data;
            end
            MODE_LOC_RD: begin
              reg_re  = 1'b1;
              reg_ra  = RA_W'(in_addr);
              reg_ok  = in_addr_ok;
              state_d = ST_LOC_CAP;
            end
          endcase
        end
      end

      // Fetch the frame header one byte a cycle
      ST_HDR0: begin
        buf_re  = 1'b1;
        buf_ra  = BA_W'(HDR_OP);
        state_d = ST_HDR1;
      end
      ST_HDR1: begin
        buf_re  = 1'b1;
        buf_ra  = BA_W'(HDR_ADDR);
        b0_d    = buf_rd;
        state_d = ST_HDR2;
      end
      ST_HDR2: begin
        buf_re  = 1'b1;
        buf_ra  = BA_W'(HDR_LEN);
        b1_d    = buf_rd;
        state_d = ST_HDR3;
      end
      ST_HDR3: begin
        state_d = ST_EMIT;
        if (mode_q == MODE_TX_MATCH) begin
          if (b0_q == FRAME_READ) begin
            read_base_d    = b1_q;
            fl_d           = snap_len;
            send_d         = '0;
            step_ctrl.load = 1'b1;
            step_start     = '0;
            step_limit     = snap_len;
            step_base      = SUM_W'(b1_q);
            state_d        = ST_SNAP_RD;
          end
        end else begin
          if (b0_q == FRAME_WRITE && SUM_W'(b1_q) >= SUM_W'(MOTION_COUNT)
              && SUM_W'(b1_q) < SUM_W'(REG_COUNT)) begin
            res_upd_d      = 1'b1;
            step_ctrl.load = 1'b1;
            step_start     = LEN_W'(WF_DATA_OFS);
            step_limit     = fl_q;
            step_base      = SUM_W'(b1_q) - SUM_W'(WF_DATA_OFS);
            state_d        = ST_WF_RD;
          end
        end
      end

      // Snapshot registers into the buffer
      ST_SNAP_RD: begin
        if (step_stat.more) begin
          reg_re  = 1'b1;
          reg_ra  = step_sum[RA_W-1:0];
          reg_ok  = step_stat.in_reg;
          state_d = ST_SNAP_WR;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SNAP_WR: begin
        buf_we            = 1'b1;
        buf_wa            = step_idx[BA_W-1:0];
        buf_wd            = reg_rd;
        step_ctrl.advance = 1'b1;
        state_d           = ST_SNAP_RD;
      end

      // Zero the motion registers that were read, then empty the buffer
      ST_CLR: begin
        if (step_stat.more) begin
          reg_we            = step_stat.in_motion && step_stat.in_reg;
          reg_wa            = step_sum[RA_W-1:0];
          reg_wd            = 8'h00;
          step_ctrl.advance = 1'b1;
        end else begin
          fl_d    = '0;
          send_d  = '0;
          state_d = ST_EMIT;
        end
      end

      // Copy write frame data into the config region
      ST_WF_RD: begin
        if (step_stat.more) begin
          buf_re  = 1'b1;
          buf_ra  = step_idx[BA_W-1:0];
          state_d = ST_WF_WR;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_WF_WR: begin
        reg_we            = step_stat.in_reg;
        reg_wa            = step_sum[RA_W-1:0];
        reg_wd            = buf_rd;
        step_ctrl.advance = 1'b1;
        state_d           = ST_WF_RD;
      end

      // Send the next buffer byte
      ST_TX_RD: begin
        buf_re  = 1'b1;
        buf_ra  = send_q[BA_W-1:0];
        state_d = ST_TX_CAP;
      end
      ST_TX_CAP: begin
        res_tx_d  = buf_rd;
        res_txv_d = 1'b1;
        send_d    = send_q + 1'b1;
        state_d   = ST_EMIT;
      end

      ST_LOC_CAP: begin
        res_rd_d = reg_rd;
        state_d  = ST_EMIT;
      end

      // Hand the result to the output register once it is free
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {res_rd_q, res_upd_q, res_txv_q, res_tx_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fl_q        <= '0;
      send_q      <= '0;
      read_base_q <= 8'h00;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      fl_q        <= fl_d;
      send_q      <= send_d;
      read_base_q <= read_base_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    b0_q      <= b0_d;
    b1_q      <= b1_d;
    res_tx_q  <= res_tx_d;
    res_txv_q <= res_txv_d;
    res_upd_q <= res_upd_d;
    res_rd_q  <= res_rd_d;
    m_data_q  <= m_data_d;
  end

  i2csrf_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (reg_we),
    .wr_addr_i (reg_wa),
    .wr_data_i (reg_wd),
    .rd_en_i   (reg_re),
    .rd_addr_i (reg_ra),
    .rd_ok_i   (reg_ok),
    .rd_data_o (reg_rd)
  );

  i2csrf_fbuf #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_fbuf (
    .clk_i     (clk_i),
    .wr_en_i   (buf_we),
    .wr_addr_i (buf_wa),
    .wr_data_i (buf_wd),
    .rd_en_i   (buf_re),
    .rd_addr_i (buf_ra),
    .rd_data_o (buf_rd)
  );

  i2csrf_step #(
    .IDX_W        (LEN_W),
    .SUM_W        (SUM_W),
    .REG_COUNT    (REG_COUNT),
    .MOTION_COUNT (MOTION_COUNT)
  ) u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (step_ctrl),
    .start_i (step_start),
    .limit_i (step_limit),
    .base_i  (step_base),
    .idx_o   (step_idx),
    .sum_o   (step_sum),
    .stat_o  (step_stat)
  );

endmodule

// File: rtl/core/i2csrf_checker.sv
// ============================================================================
// i2csrf_checker
// Port-level checks of the slave bus register file core, bound to the top.
// ============================================================================
module i2csrf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // An accepted event leaves the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted back to back");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // No transmit byte without tx_valid
  a_tx_byte_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8] || m_axis_tdata[7:0] == 8'h00))
    else $error("tx_byte set without tx_valid");

  // A result carries one kind of response only
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !((m_axis_tdata[9] && m_axis_tdata[8]) ||
                        (m_axis_tdata[9] && m_axis_tdata[17:10] != 8'h00) ||
                        (m_axis_tdata[8] && m_axis_tdata[17:10] != 8'h00)))
    else $error("result mixes response kinds");

endmodule

bind i2c_slave_register_file_core i2csrf_checker u_i2csrf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
